// ----- hdl/awfd_pkg.sv -----
// Shared types and constants of the acoustic wave finite-difference step.
// Widths of the fixed-point datapath, controller states and the command and
// status structs between controller and datapath. Depends on nothing.
package awfd_pkg;

    // Field and register widths.
    localparam int VAL_W      = 32;  // Q16.16 pressure values
    localparam int VEL_W      = 14;  // wave speed
    localparam int DT_W       = 24;  // dt/h, Q0.24
    localparam int ROWS_W     = 16;  // grid_rows register
    localparam int CFG_COLS_W = 11;  // grid_cols register
    localparam int CFG_W      = 24;  // configuration write data
    localparam int CFG_IDX_W  = 2;   // configuration register index
    localparam int IN_DATA_W  = 112; // packed input payload, padded to bytes
    localparam int OUT_DATA_W = 32;  // packed output payload

    // Internal arithmetic widths.
    localparam int PSD_W   = 34;     // 2*cur - prev + source
    localparam int LAP_W   = 35;     // five-point stencil sum
    localparam int MAG_W   = 34;     // magnitude of the stencil sum
    localparam int K_W     = 38;     // velocity * dt/h, Q14.24
    localparam int K_SHIFT = 8;
    localparam int K16_W   = K_W - K_SHIFT;
    localparam int SQ_W    = 2 * K16_W;
    localparam int SQ_SHIFT = 8;
    localparam int COEF_W  = SQ_W - SQ_SHIFT;
    localparam int MUL_STEPS = 4;
    localparam int MUL_IDX_W = 2;
    localparam int CHUNK_W = COEF_W / MUL_STEPS;
    localparam int PP_W    = MAG_W + CHUNK_W;
    localparam int ACC_W   = MAG_W + COEF_W;
    localparam int OVF_SHIFT   = 62; // product limit 2^62
    localparam int TERM_SHIFT  = 24; // coefficient is Q.24
    localparam int CLAMP_SHIFT = 36; // clamped term magnitude 2^36
    localparam int TMAG_W  = 39;
    localparam int TERM_W  = 40;
    localparam int SUM_W   = 42;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DT_OVER_H = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [ROWS_W-1:0]     RST_GRID_ROWS = 16'd100;
    localparam logic [CFG_COLS_W-1:0] RST_GRID_COLS = 11'd100;
    localparam logic [DT_W-1:0]       RST_DT_OVER_H = 24'd1678;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_CENTRE,
        ST_RD_UP,
        ST_RD_LEFT,
        ST_RD_RIGHT,
        ST_LAP,
        ST_ABS,
        ST_MUL,
        ST_TERM,
        ST_OUT,
        ST_WRITE
    } ctrl_state_t;

    typedef struct packed {
        logic                 load;       // capture the accepted request
        logic                 cap_centre; // centre, partial sum, k product
        logic                 cap_up;     // up neighbour, k16 square
        logic                 cap_left;   // left neighbour, coefficient
        logic                 lap;        // form the stencil sum
        logic                 abs;        // magnitude and sign, clear product
        logic                 mul;        // one partial product step
        logic [MUL_IDX_W-1:0] mul_idx;
        logic                 term;       // rounded, clamped stencil term
        logic                 write;      // store the point in the line stores
        logic                 out_load;   // load the output register
        logic                 up_ok;
        logic                 left_ok;
        logic                 right_ok;
        logic                 is_flush;
        logic                 frame_last;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free; // output register empty or being taken
    } dp_status_t;

endpackage

// ----- hdl/awfd_ram.sv -----
// Generic simple dual-port RAM: one write port and one registered read port.
// Used for the line stores of the wave step; depends on nothing.
module awfd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/awfd_ctrl.sv -----
// Controller of the wave step: request sequencing, grid positions and
// line store addressing. Depends on awfd_pkg.
module awfd_ctrl #(
    parameter int MAX_COLS = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_op,
    output logic                                in_ready,
    input  logic                                restart,
    input  logic [awfd_pkg::ROWS_W-1:0]         eff_rows,
    input  logic [$clog2(MAX_COLS+1)-1:0]       eff_cols,
    input  awfd_pkg::dp_status_t                status,
    output awfd_pkg::dp_cmd_t                   cmd,
    output logic [$clog2(2*MAX_COLS)-1:0]       line_raddr,
    output logic [$clog2(2*MAX_COLS)-1:0]       line_waddr,
    output logic [$clog2(MAX_COLS)-1:0]         col_addr
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int CNT_W = $clog2(MAX_COLS + 1);
    localparam int LA_W  = $clog2(2 * MAX_COLS);

    awfd_pkg::ctrl_state_t state_reg, state_next;
    logic [awfd_pkg::ROWS_W-1:0]    row_pos_reg, row_pos_next;
    logic [COL_W-1:0]               col_pos_reg, col_pos_next;
    logic [COL_W-1:0]               flush_pos_reg, flush_pos_next;
    logic                           flush_reg, flush_next;
    logic [awfd_pkg::MUL_IDX_W-1:0] mul_idx_reg, mul_idx_next;

    logic [COL_W-1:0] col;
    logic [COL_W-1:0] left_col;
    logic [COL_W-1:0] right_col;
    logic [CNT_W-1:0] col_inc;
    logic             draining;
    logic             left_ok;
    logic             right_ok;
    logic             up_ok;
    logic             advance;

    function automatic logic [LA_W-1:0] line_address(input logic bank,
                                                     input logic [COL_W-1:0] c);
        line_address = LA_W'(c) + (bank ? LA_W'(MAX_COLS) : LA_W'(0));
    endfunction

    // The stored row being finished is the one above the current row.
    assign col       = flush_reg ? flush_pos_reg : col_pos_reg;
    assign col_inc   = CNT_W'(col) + CNT_W'(1);
    assign draining  = row_pos_reg >= eff_rows;
    assign left_ok   = col != '0;
    assign right_ok  = col_inc < eff_cols;
    assign up_ok     = row_pos_reg >= awfd_pkg::ROWS_W'(2);
    assign left_col  = left_ok ? col - COL_W'(1) : col;
    assign right_col = right_ok ? col_inc[COL_W-1:0] : col;
    assign col_addr  = col;
    assign line_waddr = line_address(row_pos_reg[0], col);

    always_comb
    begin
        unique case (state_reg)
            awfd_pkg::ST_RD_UP:    line_raddr = line_address(row_pos_reg[0], col);
            awfd_pkg::ST_RD_LEFT:  line_raddr = line_address(~row_pos_reg[0], left_col);
            awfd_pkg::ST_RD_RIGHT: line_raddr = line_address(~row_pos_reg[0], right_col);
            default:               line_raddr = line_address(~row_pos_reg[0], col);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= awfd_pkg::ST_IDLE;
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            flush_pos_reg <= '0;
            flush_reg     <= 1'b0;
            mul_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            row_pos_reg   <= row_pos_next;
            col_pos_reg   <= col_pos_next;
            flush_pos_reg <= flush_pos_next;
            flush_reg     <= flush_next;
            mul_idx_reg   <= mul_idx_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        row_pos_next   = row_pos_reg;
        col_pos_next   = col_pos_reg;
        flush_pos_next = flush_pos_reg;
        flush_next     = flush_reg;
        mul_idx_next   = mul_idx_reg;
        advance        = 1'b0;
        in_ready       = 1'b0;

        cmd            = '0;
        cmd.mul_idx    = mul_idx_reg;
        cmd.up_ok      = up_ok;
        cmd.left_ok    = left_ok;
        cmd.right_ok   = right_ok;
        cmd.is_flush   = flush_reg;
        cmd.frame_last = flush_reg && !right_ok;

        unique case (state_reg)
            awfd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    // Points while draining and flushes while not are dropped.
                    if (!in_op && !draining)
                    begin
                        flush_next = 1'b0;
                        state_next = (row_pos_reg == '0) ? awfd_pkg::ST_WRITE
                                                         : awfd_pkg::ST_RD_CENTRE;
                    end
                    else if (in_op && draining)
                    begin
                        flush_next = 1'b1;
                        state_next = awfd_pkg::ST_RD_CENTRE;
                    end
                end
            end
            awfd_pkg::ST_RD_CENTRE: state_next = awfd_pkg::ST_RD_UP;
            awfd_pkg::ST_RD_UP:
            begin
                cmd.cap_centre = 1'b1;
                state_next     = awfd_pkg::ST_RD_LEFT;
            end
            awfd_pkg::ST_RD_LEFT:
            begin
                cmd.cap_up = 1'b1;
                state_next = awfd_pkg::ST_RD_RIGHT;
            end
            awfd_pkg::ST_RD_RIGHT:
            begin
                cmd.cap_left = 1'b1;
                state_next   = awfd_pkg::ST_LAP;
            end
            awfd_pkg::ST_LAP:
            begin
                cmd.lap    = 1'b1;
                state_next = awfd_pkg::ST_ABS;
            end
            awfd_pkg::ST_ABS:
            begin
                cmd.abs      = 1'b1;
                mul_idx_next = '0;
                state_next   = awfd_pkg::ST_MUL;
            end
            awfd_pkg::ST_MUL:
            begin
                cmd.mul = 1'b1;
                if (mul_idx_reg == awfd_pkg::MUL_IDX_W'(awfd_pkg::MUL_STEPS - 1))
                begin
                    state_next = awfd_pkg::ST_TERM;
                end
                else
                begin
                    mul_idx_next = mul_idx_reg + awfd_pkg::MUL_IDX_W'(1);
                end
            end
            awfd_pkg::ST_TERM:
            begin
                // All reads of this point are done, so its own entries may go.
                cmd.term   = 1'b1;
                cmd.write  = !flush_reg;
                state_next = awfd_pkg::ST_OUT;
            end
            awfd_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    advance      = 1'b1;
                    state_next   = awfd_pkg::ST_IDLE;
                end
            end
            awfd_pkg::ST_WRITE:
            begin
                cmd.write  = 1'b1;
                advance    = 1'b1;
                state_next = awfd_pkg::ST_IDLE;
            end
            default: state_next = awfd_pkg::ST_IDLE;
        endcase

        if (advance)
        begin
            if (flush_reg)
            begin
                if (!right_ok)
                begin
                    row_pos_next   = '0;
                    col_pos_next   = '0;
                    flush_pos_next = '0;
                end
                else
                begin
                    flush_pos_next = col_inc[COL_W-1:0];
                end
            end
            else if (!right_ok)
            begin
                col_pos_next = '0;
                row_pos_next = row_pos_reg + awfd_pkg::ROWS_W'(1);
            end
            else
            begin
                col_pos_next = col_inc[COL_W-1:0];
            end
        end

        // A new frame size starts a new frame.
        if (restart)
        begin
            row_pos_next   = '0;
            col_pos_next   = '0;
            flush_pos_next = '0;
        end
    end

endmodule

// ----- hdl/awfd_datapath.sv -----
// Datapath of the wave step: line stores, stencil sum, coefficient,
// multi-step product, saturation and the output register.
// Depends on awfd_pkg and awfd_ram.
module awfd_datapath #(
    parameter int MAX_COLS = 1024
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  awfd_pkg::dp_cmd_t                      cmd,
    output awfd_pkg::dp_status_t                   status,
    input  logic signed [awfd_pkg::VAL_W-1:0]      in_current,
    input  logic signed [awfd_pkg::VAL_W-1:0]      in_previous,
    input  logic [awfd_pkg::VEL_W-1:0]             in_velocity,
    input  logic signed [awfd_pkg::VAL_W-1:0]      in_source,
    input  logic [awfd_pkg::DT_W-1:0]              dt_over_h,
    input  logic [$clog2(2*MAX_COLS)-1:0]          line_raddr,
    input  logic [$clog2(2*MAX_COLS)-1:0]          line_waddr,
    input  logic [$clog2(MAX_COLS)-1:0]            col_addr,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [awfd_pkg::VAL_W-1:0]             out_value,
    output logic                                   out_last
);

    localparam int VAL_W = awfd_pkg::VAL_W;
    localparam int ACC_W = awfd_pkg::ACC_W;

    logic signed [VAL_W-1:0]            cur_reg, prev_reg, src_reg;
    logic [awfd_pkg::VEL_W-1:0]         vel_reg;
    logic signed [VAL_W-1:0]            centre_reg, up_reg, left_reg;
    logic signed [awfd_pkg::PSD_W-1:0]  psd_reg;
    logic [awfd_pkg::K_W-1:0]           k_reg;
    logic [awfd_pkg::SQ_W-1:0]          sq_reg;
    logic [awfd_pkg::COEF_W-1:0]        coef_reg;
    logic signed [awfd_pkg::LAP_W-1:0]  lap_reg;
    logic [awfd_pkg::MAG_W-1:0]         mag_reg;
    logic                               neg_reg;
    logic [ACC_W-1:0]                   acc_reg;
    logic signed [awfd_pkg::TERM_W-1:0] term_reg;
    logic [VAL_W-1:0]                   value_reg;
    logic                               last_reg;
    logic                               valid_reg, valid_next;

    logic [VAL_W-1:0]                   line_rdata;
    logic [awfd_pkg::PSD_W-1:0]         psd_rdata;
    logic [awfd_pkg::VEL_W-1:0]         vel_rdata;

    logic signed [VAL_W-1:0]            down_val, right_val;
    logic signed [awfd_pkg::LAP_W-1:0]  lap_sum, lap_abs;
    logic signed [awfd_pkg::PSD_W-1:0]  psd_new;
    logic [awfd_pkg::K_W-1:0]           k_prod, k_round;
    logic [awfd_pkg::K16_W-1:0]         k16;
    logic [awfd_pkg::SQ_W-1:0]          sq_prod, sq_round;
    logic [awfd_pkg::CHUNK_W-1:0]       chunk;
    logic [awfd_pkg::PP_W-1:0]          pp;
    logic [ACC_W-1:0]                   acc_add, acc_round;
    logic                               ovf;
    logic [awfd_pkg::TMAG_W-1:0]        tmag;
    logic signed [awfd_pkg::TERM_W-1:0] term_val;
    logic signed [awfd_pkg::SUM_W-1:0]  sum;
    logic [VAL_W-1:0]                   sat_val;

    awfd_ram #(
        .WIDTH (VAL_W),
        .DEPTH (2 * MAX_COLS)
    ) u_line_ram (
        .clk   (clk),
        .we    (cmd.write),
        .waddr (line_waddr),
        .wdata (cur_reg),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    awfd_ram #(
        .WIDTH (awfd_pkg::PSD_W),
        .DEPTH (MAX_COLS)
    ) u_psd_ram (
        .clk   (clk),
        .we    (cmd.write),
        .waddr (col_addr),
        .wdata (psd_new),
        .raddr (col_addr),
        .rdata (psd_rdata)
    );

    awfd_ram #(
        .WIDTH (awfd_pkg::VEL_W),
        .DEPTH (MAX_COLS)
    ) u_vel_ram (
        .clk   (clk),
        .we    (cmd.write),
        .waddr (col_addr),
        .wdata (vel_reg),
        .raddr (col_addr),
        .rdata (vel_rdata)
    );

    assign psd_new = (awfd_pkg::PSD_W'(cur_reg) <<< 1) - awfd_pkg::PSD_W'(prev_reg)
                     + awfd_pkg::PSD_W'(src_reg);

    // The point below is the current request, or zero when draining.
    assign down_val  = cmd.is_flush ? '0 : cur_reg;
    assign right_val = cmd.right_ok ? signed'(line_rdata) : '0;
    assign lap_sum   = awfd_pkg::LAP_W'(up_reg) + awfd_pkg::LAP_W'(down_val)
                     + awfd_pkg::LAP_W'(left_reg) + awfd_pkg::LAP_W'(right_val)
                     - (awfd_pkg::LAP_W'(centre_reg) <<< 2);
    assign lap_abs   = lap_reg[awfd_pkg::LAP_W-1] ? -lap_reg : lap_reg;

    assign k_prod   = vel_rdata * dt_over_h;
    assign k_round  = k_reg + awfd_pkg::K_W'(128);
    assign k16      = k_round[awfd_pkg::K_W-1:awfd_pkg::K_SHIFT];
    assign sq_prod  = k16 * k16;
    assign sq_round = sq_reg + awfd_pkg::SQ_W'(128);

    // Magnitude times coefficient, one slice of the coefficient per step.
    assign chunk   = coef_reg[awfd_pkg::CHUNK_W * cmd.mul_idx +: awfd_pkg::CHUNK_W];
    assign pp      = mag_reg * chunk;
    assign acc_add = acc_reg + (ACC_W'(pp) << (awfd_pkg::CHUNK_W * cmd.mul_idx));

    assign ovf       = acc_reg > (ACC_W'(1) << awfd_pkg::OVF_SHIFT);
    assign acc_round = acc_reg + (ACC_W'(1) << (awfd_pkg::TERM_SHIFT - 1));
    assign tmag      = ovf ? (awfd_pkg::TMAG_W'(1) << awfd_pkg::CLAMP_SHIFT)
                           : acc_round[awfd_pkg::TERM_SHIFT +: awfd_pkg::TMAG_W];
    assign term_val  = neg_reg ? -$signed(awfd_pkg::TERM_W'(tmag))
                               : $signed(awfd_pkg::TERM_W'(tmag));

    assign sum = awfd_pkg::SUM_W'(psd_reg) + awfd_pkg::SUM_W'(term_reg);

    always_comb
    begin
        if (!sum[awfd_pkg::SUM_W-1] && (|sum[awfd_pkg::SUM_W-2:VAL_W-1]))
        begin
            sat_val = {1'b0, {(VAL_W-1){1'b1}}};
        end
        else if (sum[awfd_pkg::SUM_W-1] && !(&sum[awfd_pkg::SUM_W-2:VAL_W-1]))
        begin
            sat_val = {1'b1, {(VAL_W-1){1'b0}}};
        end
        else
        begin
            sat_val = sum[VAL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_reg  <= in_current;
            prev_reg <= in_previous;
            vel_reg  <= in_velocity;
            src_reg  <= in_source;
        end
        if (cmd.cap_centre)
        begin
            centre_reg <= signed'(line_rdata);
            psd_reg    <= signed'(psd_rdata);
            k_reg      <= k_prod;
        end
        if (cmd.cap_up)
        begin
            up_reg <= cmd.up_ok ? signed'(line_rdata) : '0;
            sq_reg <= sq_prod;
        end
        if (cmd.cap_left)
        begin
            left_reg <= cmd.left_ok ? signed'(line_rdata) : '0;
            coef_reg <= sq_round[awfd_pkg::SQ_W-1:awfd_pkg::SQ_SHIFT];
        end
        if (cmd.lap)
        begin
            lap_reg <= lap_sum;
        end
        if (cmd.abs)
        begin
            mag_reg <= lap_abs[awfd_pkg::MAG_W-1:0];
            neg_reg <= lap_reg[awfd_pkg::LAP_W-1];
            acc_reg <= '0;
        end
        if (cmd.mul)
        begin
            acc_reg <= acc_add;
        end
        if (cmd.term)
        begin
            term_reg <= term_val;
        end
        if (cmd.out_load)
        begin
            value_reg <= sat_val;
            last_reg  <= cmd.frame_last;
        end
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign status.out_free = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_value = value_reg;
    assign out_last  = last_reg;

endmodule

// ----- hdl/acoustic_wave_fd_step_top.sv -----
// Top level of the acoustic wave finite-difference step: configuration
// registers, controller and datapath. Depends on awfd_pkg, awfd_ctrl,
// awfd_datapath and, through the datapath, awfd_ram.
//
// Requests arrive on the slave stream in raster order, one grid point each,
// with tuser low; once every row of the frame has been sent, one flush
// request per column (tuser high) drains the last row. The result for a
// point leaves on the master stream when the point below it arrives, so the
// first row gives no results and the flushes give the last row's results;
// tlast marks the frame's final result. Points sent while draining and
// flushes sent before it are swallowed without a result.
// A request that yields a result reads the centre and its up, left and
// right neighbours in turn over the single read port of the line store,
// then forms the stencil sum, the magnitude, the four-step coefficient
// product and the term, then the output state; the block takes no request
// until idle. A first-row point only writes; a swallowed one stays in idle.
// A stalled receiver holds the result in the output register; the block
// accepts no further request once its next result is ready to load.
// Reset clears the positions and loads the default frame size and dt/h;
// line stores need no clearing, as every read entry is written earlier in
// the frame. Writing grid_rows or grid_cols starts a new frame.
module acoustic_wave_fd_step_top #(
    parameter int MAX_COLS = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // current_value [31:0], previous_value [63:32], velocity [77:64],
    // source_value [109:78], zero padding [111:110]
    input  logic [awfd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // op [0]
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // next_value [31:0]
    output logic [awfd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast,
    input  logic                               cfg_we,
    input  logic [awfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [awfd_pkg::CFG_W-1:0]         cfg_data
);

    localparam int CNT_W = $clog2(MAX_COLS + 1);
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int LA_W  = $clog2(2 * MAX_COLS);

    logic [awfd_pkg::ROWS_W-1:0]     grid_rows_reg;
    logic [awfd_pkg::CFG_COLS_W-1:0] grid_cols_reg;
    logic [awfd_pkg::DT_W-1:0]       dt_over_h_reg;
    logic [awfd_pkg::ROWS_W-1:0]     eff_rows;
    logic [CNT_W-1:0]                eff_cols;
    logic                            restart;

    awfd_pkg::dp_cmd_t    dp_cmd;
    awfd_pkg::dp_status_t dp_status;
    logic [LA_W-1:0]      line_raddr;
    logic [LA_W-1:0]      line_waddr;
    logic [COL_W-1:0]     col_addr;

    // Configuration registers; a new frame size restarts the frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= awfd_pkg::RST_GRID_ROWS;
            grid_cols_reg <= awfd_pkg::RST_GRID_COLS;
            dt_over_h_reg <= awfd_pkg::RST_DT_OVER_H;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                awfd_pkg::CFG_GRID_ROWS: grid_rows_reg <= cfg_data[awfd_pkg::ROWS_W-1:0];
                awfd_pkg::CFG_GRID_COLS: grid_cols_reg <= cfg_data[awfd_pkg::CFG_COLS_W-1:0];
                awfd_pkg::CFG_DT_OVER_H: dt_over_h_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign restart = cfg_we && ((cfg_index == awfd_pkg::CFG_GRID_ROWS) ||
                                (cfg_index == awfd_pkg::CFG_GRID_COLS));

    // A zero row count means one row; the column count is held to 1..MAX_COLS.
    assign eff_rows = (grid_rows_reg == '0) ? awfd_pkg::ROWS_W'(1) : grid_rows_reg;

    always_comb
    begin
        priority if (grid_cols_reg == '0)
        begin
            eff_cols = CNT_W'(1);
        end
        else if (32'(grid_cols_reg) > MAX_COLS)
        begin
            eff_cols = CNT_W'(MAX_COLS);
        end
        else
        begin
            eff_cols = CNT_W'(grid_cols_reg);
        end
    end

    awfd_ctrl #(
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_op      (s_axis_tuser),
        .in_ready   (s_axis_tready),
        .restart    (restart),
        .eff_rows   (eff_rows),
        .eff_cols   (eff_cols),
        .status     (dp_status),
        .cmd        (dp_cmd),
        .line_raddr (line_raddr),
        .line_waddr (line_waddr),
        .col_addr   (col_addr)
    );

    awfd_datapath #(
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (dp_cmd),
        .status      (dp_status),
        .in_current  (s_axis_tdata[31:0]),
        .in_previous (s_axis_tdata[63:32]),
        .in_velocity (s_axis_tdata[77:64]),
        .in_source   (s_axis_tdata[109:78]),
        .dt_over_h   (dt_over_h_reg),
        .line_raddr  (line_raddr),
        .line_waddr  (line_waddr),
        .col_addr    (col_addr),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_value   (m_axis_tdata),
        .out_last    (m_axis_tlast)
    );

    // A result is only loaded when the previous one is gone or leaving.
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result loaded over an untaken result");

    // The output only becomes valid through a load by the controller.
    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(dp_cmd.out_load))
        else $error("output valid without a result load");

    // Line stores are written only while no new request can be taken.
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.write |-> !s_axis_tready)
        else $error("line store written while accepting a request");

endmodule

// ----- tb/acoustic_wave_fd_step_top_tb.sv -----
// Self-checking testbench of the acoustic wave finite-difference step.
// Holds its own bit-exact predictor of the stencil pipeline and drives the
// streams and the register port of acoustic_wave_fd_step_top; needs awfd_pkg.
`timescale 1ns / 100ps

module acoustic_wave_fd_step_top_tb;
    import awfd_pkg::*;

    // Column capacity of the instance and of the predictor's line stores.
    localparam int unsigned GRID_COL_LIMIT = 1024;

    // Request kinds carried on tuser, and the one register index that the
    // block does not implement.
    localparam logic OP_POINT = 1'b0;
    localparam logic OP_FLUSH = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    // Quiet time after the last owed result, so that a swallowed request or a
    // first-row point finishes as well.
    localparam int SETTLE_CYCLES = 24;
    localparam int LONG_HOLD = 300;
    localparam int RANDOM_ITEMS = 1550;
    localparam longint TIMEOUT_NS = 5_000_000;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    typedef struct packed {
        logic             op;
        logic [VAL_W-1:0] current_value;
        logic [VAL_W-1:0] previous_value;
        logic [VEL_W-1:0] velocity;
        logic [VAL_W-1:0] source_value;
    } wave_req_t;

    typedef struct packed {
        logic [VAL_W-1:0] next_value;
        logic             frame_last;
    } wave_res_t;

    typedef enum logic {
        ENTRY_WRITE,
        ENTRY_REQUEST
    } entry_kind_t;

    // One row of the directed stimulus: either a register write or a
    // request, the latter optionally with its result written out by hand.
    typedef struct {
        entry_kind_t          kind;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     value;
        wave_req_t            req;
        bit                   typed;
        wave_res_t            result;
    } plan_entry_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    acoustic_wave_fd_step_top #(
        .MAX_COLS (GRID_COL_LIMIT)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: a copy of the registers, the two-row store of
    // current values, and per column the partial sum 2*cur - prev + source
    // and the velocity of the row above, plus the raster positions.
    // ------------------------------------------------------------------
    logic [ROWS_W-1:0]     model_rows;
    logic [CFG_COLS_W-1:0] model_cols;
    logic [DT_W-1:0]       model_dt;
    logic signed [VAL_W-1:0] row_store [0:2*GRID_COL_LIMIT-1];
    longint                partial_store [0:GRID_COL_LIMIT-1];
    logic [VEL_W-1:0]      speed_store [0:GRID_COL_LIMIT-1];
    int unsigned           row_pos;
    int unsigned           col_pos;
    int unsigned           flush_pos;

    // Results still owed by the block, oldest first.
    wave_res_t next_pressure_q[$];
    plan_entry_t directed_plan[$];

    int unsigned error_count = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_idle_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned random_sent = 0;
    bit hold_asked = 1'b0;
    bit last_frame_cut = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs or loses a result.
    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 50)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic int unsigned active_rows();
        return (model_rows == 0) ? 1 : model_rows;
    endfunction

    function automatic int unsigned active_cols();
        if (model_cols == 0)
            return 1;
        if (model_cols > GRID_COL_LIMIT)
            return GRID_COL_LIMIT;
        return model_cols;
    endfunction

    function automatic longint stored_value(input int unsigned bank, input int unsigned col);
        return row_store[(bank % 2) * GRID_COL_LIMIT + (col % GRID_COL_LIMIT)];
    endfunction

    // Next pressure of column c in stored row rr, given the value below it.
    // The coefficient is (v*dt/h)^2 in Q.24; the stencil term is rounded half
    // away from zero and forced to 2^36 once the product would pass 2^62.
    function automatic logic [VAL_W-1:0] next_pressure(input int unsigned rr,
                                                      input int unsigned c,
                                                      input longint below);
        longint centre, above, left_v, right_v, lap, term, total;
        longint unsigned k, k16, coef, mag, tmag;
        centre  = stored_value(rr, c);
        above   = (rr >= 1) ? stored_value(rr + 1, c) : 64'sd0;
        left_v  = (c > 0) ? stored_value(rr, c - 1) : 64'sd0;
        right_v = (c + 1 < active_cols()) ? stored_value(rr, c + 1) : 64'sd0;
        lap = above + below + left_v + right_v - 4 * centre;
        k = {50'd0, speed_store[c]} * {40'd0, model_dt};
        k16 = (k + 64'd128) >> 8;
        coef = (k16 * k16 + 64'd128) >> 8;
        mag = (lap < 0) ? -lap : lap;
        if (coef != 0 && mag > (64'd1 << 62) / coef)
            tmag = 64'd1 << 36;
        else
            tmag = (mag * coef + (64'd1 << 23)) >> 24;
        term = (lap < 0) ? -longint'(tmag) : longint'(tmag);
        total = partial_store[c] + term;
        if (total > SAT_HI)
            total = SAT_HI;
        if (total < SAT_LO)
            total = SAT_LO;
        return total[VAL_W-1:0];
    endfunction

    // Advances the predictor by one accepted request; returns 1 with the
    // expected result where the request produces one.
    function automatic bit step_wave_grid(input wave_req_t req, output wave_res_t res);
        int unsigned rows_n, cols_n, r, c;
        longint cur, prev_v, src_v;
        bit draining;
        bit produced;
        rows_n = active_rows();
        cols_n = active_cols();
        draining = row_pos >= rows_n;
        res = '0;
        produced = 1'b0;
        if (req.op == OP_POINT)
        begin
            if (draining)
                return 1'b0;
            r = row_pos;
            c = col_pos % GRID_COL_LIMIT;
            cur = $signed(req.current_value);
            prev_v = $signed(req.previous_value);
            src_v = $signed(req.source_value);
            if (r >= 1)
            begin
                res.next_value = next_pressure(r - 1, c, cur);
                produced = 1'b1;
            end
            row_store[(r % 2) * GRID_COL_LIMIT + c] = req.current_value;
            partial_store[c] = 2 * cur - prev_v + src_v;
            speed_store[c] = req.velocity;
            col_pos++;
            if (col_pos >= cols_n)
            begin
                col_pos = 0;
                row_pos++;
            end
            return produced;
        end
        if (!draining)
            return 1'b0;
        c = flush_pos % GRID_COL_LIMIT;
        res.next_value = next_pressure(rows_n - 1, c, 64'sd0);
        flush_pos++;
        if (flush_pos >= cols_n)
        begin
            res.frame_last = 1'b1;
            row_pos = 0;
            col_pos = 0;
            flush_pos = 0;
        end
        return 1'b1;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] index,
                                           input logic [CFG_W-1:0] value);
        case (index)
            CFG_GRID_ROWS: model_rows = value[ROWS_W-1:0];
            CFG_GRID_COLS: model_cols = value[CFG_COLS_W-1:0];
            CFG_DT_OVER_H: model_dt = value[DT_W-1:0];
            default: ;
        endcase
        // Changing the frame size starts a fresh frame.
        if (index == CFG_GRID_ROWS || index == CFG_GRID_COLS)
        begin
            row_pos = 0;
            col_pos = 0;
            flush_pos = 0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Random values. Most pressures are small so that the stencil term is
    // visible in the result; the rest cover the full range and the rails.
    // ------------------------------------------------------------------
    function automatic logic [VAL_W-1:0] pick_pressure();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
        if (pick < 90)
            return $urandom();
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'h0000_0001;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [VEL_W-1:0] pick_speed();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return $urandom_range(300, 12000);
        if (pick < 90)
            return $urandom_range(0, 16383);
        return $urandom_range(0, 1) ? 14'h3FFF : 14'h0000;
    endfunction

    function automatic logic [DT_W-1:0] pick_dt();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return $urandom_range(200, 2000);
        if (pick < 60)
            return RST_DT_OVER_H;
        if (pick < 75)
            return $urandom_range(0, 24'hFF_FFFF);
        if (pick < 85)
            return 24'h00_0000;
        if (pick < 95)
            return 24'hFF_FFFF;
        return $urandom_range(0, 255);
    endfunction

    function automatic wave_req_t random_request(input logic op);
        wave_req_t req;
        req.op = op;
        req.current_value = pick_pressure();
        req.previous_value = pick_pressure();
        req.velocity = pick_speed();
        req.source_value = pick_pressure();
        return req;
    endfunction

    // ------------------------------------------------------------------
    // Drivers. Everything is driven with nonblocking assignments just after
    // the rising edge; handshakes are sampled in the same place, so they see
    // the values that were present at the edge.
    // ------------------------------------------------------------------
    task automatic send_request(input wave_req_t req, input bit typed,
                                input wave_res_t typed_res);
        wave_res_t res;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req.op;
        s_axis_tdata <= {2'b00, req.source_value, req.velocity,
                         req.previous_value, req.current_value};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (step_wave_grid(req, res))
            next_pressure_q.push_back(typed ? typed_res : res);
    endtask

    // Registers are only touched when the block is idle, so the write strobe
    // is dropped again before anything else is driven.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        apply_register(index, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering requests and wait until every owed result has been
    // taken, then let any swallowed or first-row request finish as well.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (next_pressure_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: checks every accepted result against the oldest
    // expectation and decides tready for the next cycle. A long hold, when
    // asked for, keeps tready low over a countdown from LONG_HOLD so that the
    // block backs up into its input while the sender keeps offering requests.
    // ------------------------------------------------------------------
    initial
    begin
        wave_res_t want;
        int unsigned holds_served;
        int hold_left;
        bit ready_next;
        holds_served = 0;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            begin
                if (next_pressure_q.size() == 0)
                    report_mismatch($sformatf("result %h with nothing expected",
                                              m_axis_tdata));
                else
                begin
                    want = next_pressure_q.pop_front();
                    if (m_axis_tdata[VAL_W-1:0] !== want.next_value)
                        report_mismatch($sformatf("next_value %h, expected %h",
                                                  m_axis_tdata, want.next_value));
                    if (m_axis_tlast !== want.frame_last)
                        report_mismatch($sformatf("frame_last %b, expected %b",
                                                  m_axis_tlast, want.frame_last));
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else if (holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = LONG_HOLD - 1;
                ready_next = 1'b0;
            end
            else
                ready_next = ($urandom_range(0, 99) >= receiver_idle_pct);
            m_axis_tready <= ready_next;
        end
    end

    // ------------------------------------------------------------------
    // Directed table. The first frame runs with dt/h at zero, so the
    // stencil term vanishes and each result is just the saturated partial
    // sum of the point above; those rows carry their results by hand. It
    // covers both rails of every pressure field, a flush offered before the
    // frame is drained, a point offered while draining, the row and column
    // registers at zero, an unused register index (which must not restart
    // the frame) and a stencil term large enough to be clamped.
    // ------------------------------------------------------------------
    function automatic plan_entry_t reg_entry(input logic [CFG_IDX_W-1:0] index,
                                              input logic [CFG_W-1:0] value);
        plan_entry_t e;
        e.kind = ENTRY_WRITE;
        e.index = index;
        e.value = value;
        e.req = '0;
        e.typed = 1'b0;
        e.result = '0;
        return e;
    endfunction

    function automatic plan_entry_t req_entry(input logic op, input logic [31:0] cur,
                                              input logic [31:0] prev,
                                              input logic [13:0] vel,
                                              input logic [31:0] src, input bit typed,
                                              input logic [31:0] next, input logic last);
        plan_entry_t e;
        e.kind = ENTRY_REQUEST;
        e.index = '0;
        e.value = '0;
        e.req = '{op, cur, prev, vel, src};
        e.typed = typed;
        e.result = '{next, last};
        return e;
    endfunction

    task automatic build_directed_plan();
        directed_plan.push_back(reg_entry(CFG_GRID_ROWS, 24'd2));
        directed_plan.push_back(reg_entry(CFG_GRID_COLS, 24'd3));
        directed_plan.push_back(reg_entry(CFG_DT_OVER_H, 24'd0));
        // First row: no results, only stored.
        directed_plan.push_back(req_entry(OP_POINT, 32'h0001_0000, 32'h0000_0000, 14'h3FFF,
                                          32'h0000_0000, 1'b0, '0, 1'b0));
        directed_plan.push_back(req_entry(OP_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 14'h0000,
                                          32'h7FFF_FFFF, 1'b0, '0, 1'b0));
        directed_plan.push_back(req_entry(OP_POINT, 32'h8000_0000, 32'h7FFF_FFFF, 14'h2AAA,
                                          32'h8000_0000, 1'b0, '0, 1'b0));
        // A flush before the frame is drained is swallowed.
        directed_plan.push_back(req_entry(OP_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 14'h3FFF,
                                          32'hFFFF_FFFF, 1'b0, '0, 1'b0));
        // Second row releases the first row: 2.0, then both rails.
        directed_plan.push_back(req_entry(OP_POINT, 32'h0000_0000, 32'h0001_0000, 14'h1555,
                                          32'h0000_0000, 1'b1, 32'h0002_0000, 1'b0));
        directed_plan.push_back(req_entry(OP_POINT, 32'h0000_0000, 32'h0001_0000, 14'h1555,
                                          32'h0000_0000, 1'b1, 32'h7FFF_FFFF, 1'b0));
        directed_plan.push_back(req_entry(OP_POINT, 32'h0000_0000, 32'h0001_0000, 14'h1555,
                                          32'h0000_0000, 1'b1, 32'h8000_0000, 1'b0));
        // Draining the last row: each point there holds -1.0.
        directed_plan.push_back(req_entry(OP_FLUSH, 32'h0000_0000, 32'h0000_0000, 14'h0000,
                                          32'h0000_0000, 1'b1, 32'hFFFF_0000, 1'b0));
        // A point while draining is swallowed.
        directed_plan.push_back(req_entry(OP_POINT, 32'h1234_5678, 32'h0000_0000, 14'h0001,
                                          32'h0000_0000, 1'b0, '0, 1'b0));
        directed_plan.push_back(req_entry(OP_FLUSH, 32'h0000_0000, 32'h0000_0000, 14'h0000,
                                          32'h0000_0000, 1'b1, 32'hFFFF_0000, 1'b0));
        directed_plan.push_back(req_entry(OP_FLUSH, 32'h0000_0000, 32'h0000_0000, 14'h0000,
                                          32'h0000_0000, 1'b1, 32'hFFFF_0000, 1'b1));
        // One-point frame from zero registers, at the largest dt/h and speed:
        // the stencil term is clamped and drives the sum to the negative rail.
        directed_plan.push_back(reg_entry(CFG_DT_OVER_H, 24'hFF_FFFF));
        directed_plan.push_back(reg_entry(CFG_GRID_ROWS, 24'd0));
        directed_plan.push_back(reg_entry(CFG_GRID_COLS, 24'd0));
        directed_plan.push_back(req_entry(OP_POINT, 32'h7FFF_FFFF, 32'h0000_0000, 14'h3FFF,
                                          32'h0000_0000, 1'b0, '0, 1'b0));
        directed_plan.push_back(req_entry(OP_FLUSH, 32'h0000_0000, 32'h0000_0000, 14'h0000,
                                          32'h0000_0000, 1'b1, 32'h8000_0000, 1'b1));
        // The unused index between a point and its flush must leave the frame
        // alone; zero speed gives a zero coefficient, so the result is 2.0.
        directed_plan.push_back(req_entry(OP_POINT, 32'h0001_0000, 32'h0000_0000, 14'h0000,
                                          32'h0000_0000, 1'b0, '0, 1'b0));
        directed_plan.push_back(reg_entry(CFG_SPARE_INDEX, 24'hFF_FFFF));
        directed_plan.push_back(req_entry(OP_FLUSH, 32'h0000_0000, 32'h0000_0000, 14'h0000,
                                          32'h0000_0000, 1'b1, 32'h0002_0000, 1'b1));
    endtask

    // Asks the result side for one long hold, once early on and now and
    // then afterwards, always while points are being offered.
    task automatic maybe_ask_hold();
        if ((!hold_asked && random_sent >= 100) || $urandom_range(0, 399) == 0)
        begin
            hold_asked = 1'b1;
            hold_requests++;
        end
    endtask

    // One random frame: new geometry and perhaps a new dt/h while idle,
    // the points in raster order with the odd stray flush, then the flushes
    // with the odd stray point. Some frames are abandoned part way, which
    // the next frame's register write cleans up; a few change dt/h in the
    // middle of the frame, which must not restart it.
    task automatic run_frame();
        int unsigned pick, new_rows, new_cols, total_points, stop_at, dt_at, p, f;
        bit cut_short;
        bit rows_written;
        pick = $urandom_range(0, 99);
        cut_short = ($urandom_range(0, 9) == 0);
        if (pick < 70)
        begin
            new_rows = $urandom_range(2, 5);
            new_cols = $urandom_range(3, 10);
        end
        else if (pick < 84)
        begin
            new_rows = $urandom_range(0, 3);
            new_cols = $urandom_range(0, 2);
        end
        else if (pick < 95)
        begin
            new_rows = $urandom_range(2, 3);
            new_cols = $urandom_range(16, 48);
        end
        else
        begin
            new_rows = $urandom_range(0, 1) ? 65535 : $urandom_range(256, 65534);
            new_cols = $urandom_range(3, 6);
            cut_short = 1'b1;
        end

        settle();
        rows_written = 1'b0;
        if (new_rows != model_rows || (last_frame_cut && $urandom_range(0, 1) == 1))
        begin
            write_register(CFG_GRID_ROWS, new_rows);
            rows_written = 1'b1;
        end
        if (new_cols != model_cols || (last_frame_cut && !rows_written))
            write_register(CFG_GRID_COLS, new_cols);
        if ($urandom_range(0, 2) == 0)
            write_register(CFG_DT_OVER_H, pick_dt());

        total_points = active_rows() * active_cols();
        if (total_points < 2)
            cut_short = 1'b0;
        if (!cut_short)
            stop_at = total_points;
        else if (total_points > 4 * active_cols())
            stop_at = $urandom_range(1, 4 * active_cols());
        else
            stop_at = $urandom_range(1, total_points - 1);
        dt_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, stop_at) : stop_at + 1;

        for (p = 0; p < stop_at; p++)
        begin
            if (p == dt_at)
            begin
                settle();
                write_register(CFG_DT_OVER_H, pick_dt());
            end
            if ($urandom_range(0, 39) == 0)
                send_request(random_request(OP_FLUSH), 1'b0, '0);
            maybe_ask_hold();
            send_request(random_request(OP_POINT), 1'b0, '0);
            random_sent++;
        end
        if (!cut_short)
        begin
            for (f = 0; f < active_cols(); f++)
            begin
                if ($urandom_range(0, 29) == 0)
                    send_request(random_request(OP_POINT), 1'b0, '0);
                send_request(random_request(OP_FLUSH), 1'b0, '0);
                random_sent++;
            end
        end
        last_frame_cut = cut_short;
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, one wide frame with the column
    // register above the block's capacity, then random frames under three
    // idling regimes.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= OP_POINT;
        cfg_we <= 1'b0;
        cfg_index <= CFG_GRID_ROWS;
        cfg_data <= '0;
        model_rows = RST_GRID_ROWS;
        model_cols = RST_GRID_COLS;
        model_dt = RST_DT_OVER_H;
        row_pos = 0;
        col_pos = 0;
        flush_pos = 0;
        sender_idle_pct = 10;
        receiver_idle_pct = 58;
        build_directed_plan();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == ENTRY_WRITE)
            begin
                settle();
                write_register(directed_plan[i].index, directed_plan[i].value);
            end
            else
                send_request(directed_plan[i].req, directed_plan[i].typed,
                             directed_plan[i].result);
        end

        // The column register at its top value must act as the capacity:
        // the second row, and with it the first results, starts after
        // exactly that many points. The frame is left unfinished.
        settle();
        write_register(CFG_GRID_ROWS, 24'd2);
        write_register(CFG_GRID_COLS, 24'h0007FF);
        write_register(CFG_DT_OVER_H, RST_DT_OVER_H);
        repeat (GRID_COL_LIMIT + 8)
            send_request(random_request(OP_POINT), 1'b0, '0);
        last_frame_cut = 1'b1;

        while (random_sent < RANDOM_ITEMS)
        begin
            if (random_sent < RANDOM_ITEMS / 3)
            begin
                sender_idle_pct = 10;
                receiver_idle_pct = 58;
            end
            else if (random_sent < 2 * RANDOM_ITEMS / 3)
            begin
                sender_idle_pct = 58;
                receiver_idle_pct = 10;
            end
            else
            begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            run_frame();
        end

        settle();
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
